// ===== hdl/fpl_pkg.sv =====
// Shared constants, request/response types and helper functions for the ladder filter.
`default_nettype none
package fpl_pkg;

    localparam int SAMPLE_RATE_DEF  = 96000;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int STATE_WIDTH_DEF  = 32;

    localparam int DW        = 64;
    localparam int CORDIC_N  = 30;
    localparam int CORDIC_CW = $clog2(CORDIC_N);
    localparam int DIV_CW    = $clog2(DW);

    localparam logic [31:0]        PI_Q30    = 32'd3373259426;
    localparam logic signed [63:0] THETA_MAX = 64'sd1652897119;
    localparam logic signed [63:0] ONE       = 64'sd16777216;
    localparam logic signed [63:0] G_MAX     = 64'sd1073741824;
    localparam logic [24:0]        ONE25     = 25'h1000000;
    localparam logic [31:0]        COMP_Q24  = 32'd7549747;
    localparam logic [25:0]        R_SCALE   = 26'd1792;
    localparam logic [15:0]        RES_MAX   = 16'd32768;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIMODE = 2'd1;

    typedef struct packed {
        logic              start;
        logic signed [63:0] a;
        logic [31:0]       c;
        logic [5:0]        sh;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        logic signed [63:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        valid;
        logic [63:0] q;
    } t_div_rsp;

    typedef struct packed {
        logic              start;
        logic              vec;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_cor_req;

    typedef struct packed {
        logic              valid;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_cor_rsp;

    // atan(2^-i) in Q2.30
    function automatic logic [30:0] atan_q30(input logic [CORDIC_CW-1:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    // integer square root, used only on elaboration-time constants
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/four_pole_ladder_lowpass_top.sv =====
// Top level: sequencer of the zero-delay-feedback four-pole ladder low-pass filter.
// A sequencer walks each accepted sample through one shared 64 x 32 multiplier
// (18 products), one bit-serial divider (4 quotients: phase, tan, pole coefficient and
// the feedback solve) and one CORDIC (used for tan and for the atan limiter).
// The input is ready only while idle, so a new sample waits until the last is finished; ready
// returns in the same cycle as the result appears. The last step waits while the previous
// result still sits untaken in the output register. A finished sample stays in the output
// register until taken, and the next sample may be accepted meanwhile. Configuration
// writes are always ready and should be issued only while the filter is idle.
`default_nettype none
module four_pole_ladder_lowpass_top #(
    parameter int SAMPLE_RATE  = fpl_pkg::SAMPLE_RATE_DEF,
    parameter int SAMPLE_WIDTH = fpl_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = fpl_pkg::STATE_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   i_sample_in,
    input  wire logic [15:0]                      i_cutoff_hz,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [15:0]                      i_cfg_data
);

    localparam int SW  = STATE_WIDTH;
    localparam int FB  = SAMPLE_WIDTH - 1;
    localparam int LSH = (FB <= 24) ? (24 - FB) : 0;
    localparam int RSH = (FB > 24) ? (FB - 24) : 0;
    localparam logic signed [63:0] RND    = (LSH > 0) ? (64'sd1 <<< (LSH - 1)) : 64'sd0;
    localparam logic signed [63:0] O_MAX  = (64'sd1 <<< FB) - 64'sd1;
    localparam logic signed [63:0] O_MIN  = -(64'sd1 <<< FB);
    localparam logic signed [63:0] ST_MAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [63:0] ST_MIN = -(64'sd1 <<< (SW - 1));

    // damping k = 970/sqrt(44000*fs): Q32 and its inverse in Q24
    localparam logic [63:0] ROOT_RAW = fpl_pkg::isqrt64((64'd44000 * 64'(SAMPLE_RATE)) << 30);
    localparam logic [63:0] ROOT     = (ROOT_RAW < 64'd1) ? 64'd1 : ROOT_RAW;
    localparam logic [63:0] KQ32     = (64'd970 << 47) / ROOT;
    localparam logic [63:0] KINV     = (ROOT * 64'd512) / 64'd970;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_THETA = 5'd1;
    localparam logic [4:0] ST_TAN   = 5'd2;
    localparam logic [4:0] ST_GDIV  = 5'd3;
    localparam logic [4:0] ST_LPC   = 5'd4;
    localparam logic [4:0] ST_S1    = 5'd5;
    localparam logic [4:0] ST_S2    = 5'd6;
    localparam logic [4:0] ST_S3    = 5'd7;
    localparam logic [4:0] ST_S4    = 5'd8;
    localparam logic [4:0] ST_G1    = 5'd9;
    localparam logic [4:0] ST_G2    = 5'd10;
    localparam logic [4:0] ST_SR    = 5'd11;
    localparam logic [4:0] ST_GR    = 5'd12;
    localparam logic [4:0] ST_Y0    = 5'd13;
    localparam logic [4:0] ST_P1    = 5'd14;
    localparam logic [4:0] ST_K1    = 5'd15;
    localparam logic [4:0] ST_ATAN  = 5'd16;
    localparam logic [4:0] ST_K2    = 5'd17;
    localparam logic [4:0] ST_P2    = 5'd18;
    localparam logic [4:0] ST_P3    = 5'd19;
    localparam logic [4:0] ST_P4    = 5'd20;
    localparam logic [4:0] ST_X1    = 5'd21;
    localparam logic [4:0] ST_X2    = 5'd22;
    localparam logic [4:0] ST_C1    = 5'd23;
    localparam logic [4:0] ST_C2    = 5'd24;

    function automatic logic signed [SW-1:0] sat_st(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
        return c[SW-1:0];
    endfunction

    function automatic logic signed [63:0] ext(input logic signed [SW-1:0] v);
        return 64'(v);
    endfunction

    fpl_pkg::t_mul_req mul_req;
    fpl_pkg::t_mul_rsp mul_rsp;
    fpl_pkg::t_div_req div_req;
    fpl_pkg::t_div_rsp div_rsp;
    fpl_pkg::t_cor_req cor_req;
    fpl_pkg::t_cor_rsp cor_rsp;

    logic [4:0]                      r_state, n_state;
    logic signed [63:0]              r_x, n_x;
    logic signed [63:0]              r_acc, n_acc;
    logic signed [63:0]              r_mc, n_mc;
    logic [24:0]                     r_lpc, n_lpc;
    logic [24:0]                     r_ml, n_ml;
    logic [24:0]                     r_g2, n_g2;
    logic [24:0]                     r_t, n_t;
    logic [25:0]                     r_r24, n_r24;
    logic                            r_neg, n_neg;
    logic signed [SW-1:0]            r_s1, n_s1;
    logic signed [SW-1:0]            r_s2, n_s2;
    logic signed [SW-1:0]            r_s3, n_s3;
    logic signed [SW-1:0]            r_s4, n_s4;
    logic signed [SW-1:0]            r_y1, n_y1;
    logic signed [SW-1:0]            r_y2, n_y2;
    logic signed [SW-1:0]            r_y3, n_y3;
    logic signed [SW-1:0]            r_mixb, n_mixb;
    logic signed [SAMPLE_WIDTH-1:0]  r_o, n_o;
    logic                            r_ov, n_ov;
    logic [15:0]                     r_res;
    logic [15:0]                     r_pos;

    logic signed [63:0] p;
    logic signed [63:0] sum;
    logic signed [63:0] mag;
    logic signed [63:0] qs;
    logic signed [63:0] oc;
    logic [63:0]        uq;
    logic signed [SW-1:0] yt;
    logic signed [SW-1:0] st;
    logic [15:0]        res_sat;
    logic [47:0]        th_num;
    logic signed [63:0] xs64;
    logic [23:0]        tfrac;

    fpl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    fpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fpl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
            r_pos <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fpl_pkg::CFG_RESONANCE: r_res <= i_cfg_data;
                fpl_pkg::CFG_MULTIMODE: r_pos <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_acc   = r_acc;
        n_mc    = r_mc;
        n_lpc   = r_lpc;
        n_ml    = r_ml;
        n_g2    = r_g2;
        n_t     = r_t;
        n_r24   = r_r24;
        n_neg   = r_neg;
        n_s1    = r_s1;
        n_s2    = r_s2;
        n_s3    = r_s3;
        n_s4    = r_s4;
        n_y1    = r_y1;
        n_y2    = r_y2;
        n_y3    = r_y3;
        n_mixb  = r_mixb;
        n_o     = r_o;
        n_ov    = r_ov & ~i_out_ready;
        mul_req = '0;
        div_req = '0;
        cor_req = '0;
        p       = mul_rsp.p;
        sum     = '0;
        mag     = '0;
        qs      = '0;
        oc      = '0;
        uq      = '0;
        yt      = '0;
        st      = '0;
        res_sat = (r_res > fpl_pkg::RES_MAX) ? fpl_pkg::RES_MAX : r_res;
        th_num  = 48'(i_cutoff_hz) * 48'(fpl_pkg::PI_Q30);
        xs64    = 64'(i_sample_in);
        tfrac   = {r_pos[13:0], 10'd0};

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_x           = (xs64 <<< LSH) >>> RSH;
                    n_r24         = 26'(res_sat) * fpl_pkg::R_SCALE;
                    div_req.start = 1'b1;
                    div_req.num   = 64'(th_num);
                    div_req.den   = 64'(SAMPLE_RATE);
                    n_state       = ST_THETA;
                end
            end
            ST_THETA: begin
                if (div_rsp.valid) begin
                    uq = (div_rsp.q > fpl_pkg::THETA_MAX) ? fpl_pkg::THETA_MAX : div_rsp.q;
                    cor_req.start = 1'b1;
                    cor_req.vec   = 1'b0;
                    cor_req.x     = 64'sd1 <<< 30;
                    cor_req.y     = '0;
                    cor_req.z     = $signed(uq);
                    n_state       = ST_TAN;
                end
            end
            ST_TAN: begin
                if (cor_rsp.valid) begin
                    // degenerate rotation: clamp sine at zero and cosine at one LSB
                    sum = cor_rsp.y[63] ? 64'sd0 : cor_rsp.y;
                    mag = (cor_rsp.x < 64'sd1) ? 64'sd1 : cor_rsp.x;
                    div_req.start = 1'b1;
                    div_req.num   = sum << 24;
                    div_req.den   = mag;
                    n_state       = ST_GDIV;
                end
            end
            ST_GDIV: begin
                if (div_rsp.valid) begin
                    uq = (div_rsp.q > fpl_pkg::G_MAX) ? fpl_pkg::G_MAX : div_rsp.q;
                    div_req.start = 1'b1;
                    div_req.num   = uq << 24;
                    div_req.den   = uq + fpl_pkg::ONE;
                    n_state       = ST_LPC;
                end
            end
            ST_LPC: begin
                if (div_rsp.valid) begin
                    n_lpc         = div_rsp.q[24:0];
                    n_ml          = fpl_pkg::ONE25 - div_rsp.q[24:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(r_s1);
                    mul_req.c     = 32'(div_rsp.q[24:0]);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_S1;
                end
            end
            ST_S1, ST_S2: begin
                if (mul_rsp.valid) begin
                    sum           = p + ((r_state == ST_S1) ? ext(r_s2) : ext(r_s3));
                    n_acc         = sum;
                    mul_req.start = 1'b1;
                    mul_req.a     = sum;
                    mul_req.c     = 32'(r_lpc);
                    mul_req.sh    = 6'd24;
                    n_state       = (r_state == ST_S1) ? ST_S2 : ST_S3;
                end
            end
            ST_S3: begin
                if (mul_rsp.valid) begin
                    sum           = p + ext(r_s4);
                    mul_req.start = 1'b1;
                    mul_req.a     = sum;
                    mul_req.c     = 32'(r_ml);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_S4;
                end
            end
            ST_S4: begin
                if (mul_rsp.valid) begin
                    n_acc         = p;
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(r_lpc);
                    mul_req.c     = 32'(r_lpc);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_G1;
                end
            end
            ST_G1: begin
                if (mul_rsp.valid) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = p;
                    mul_req.c     = p[31:0];
                    mul_req.sh    = 6'd24;
                    n_state       = ST_G2;
                end
            end
            ST_G2: begin
                if (mul_rsp.valid) begin
                    n_g2          = p[24:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = r_acc;
                    mul_req.c     = 32'(r_r24);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_SR;
                end
            end
            ST_SR: begin
                if (mul_rsp.valid) begin
                    n_acc         = r_x - p;
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(r_g2);
                    mul_req.c     = 32'(r_r24);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_GR;
                end
            end
            ST_GR: begin
                if (mul_rsp.valid) begin
                    // feedback solve on the magnitude, sign restored afterwards
                    n_neg         = r_acc[63];
                    mag           = r_acc[63] ? -r_acc : r_acc;
                    div_req.start = 1'b1;
                    div_req.num   = mag << 24;
                    div_req.den   = fpl_pkg::ONE + p;
                    n_state       = ST_Y0;
                end
            end
            ST_Y0: begin
                if (div_rsp.valid) begin
                    qs            = r_neg ? -$signed(div_rsp.q) : $signed(div_rsp.q);
                    yt            = sat_st(qs);
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(yt) - ext(r_s1);
                    mul_req.c     = 32'(r_lpc);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_P1;
                end
            end
            ST_P1: begin
                if (mul_rsp.valid) begin
                    yt            = sat_st(p + ext(r_s1));
                    st            = sat_st(ext(yt) + p);
                    n_y1          = yt;
                    n_s1          = st;
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(st);
                    mul_req.c     = KQ32[31:0];
                    mul_req.sh    = 6'd32;
                    n_state       = ST_K1;
                end
            end
            ST_K1: begin
                if (mul_rsp.valid) begin
                    cor_req.start = 1'b1;
                    cor_req.vec   = 1'b1;
                    cor_req.x     = fpl_pkg::ONE;
                    cor_req.y     = p;
                    cor_req.z     = '0;
                    n_state       = ST_ATAN;
                end
            end
            ST_ATAN: begin
                if (cor_rsp.valid) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = cor_rsp.z >>> 6;
                    mul_req.c     = KINV[31:0];
                    mul_req.sh    = 6'd24;
                    n_state       = ST_K2;
                end
            end
            ST_K2: begin
                if (mul_rsp.valid) begin
                    n_s1          = sat_st(p);
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(r_y1) - ext(r_s2);
                    mul_req.c     = 32'(r_lpc);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_P2;
                end
            end
            ST_P2: begin
                if (mul_rsp.valid) begin
                    yt            = sat_st(p + ext(r_s2));
                    n_y2          = yt;
                    n_s2          = sat_st(ext(yt) + p);
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(yt) - ext(r_s3);
                    mul_req.c     = 32'(r_lpc);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_P3;
                end
            end
            ST_P3: begin
                if (mul_rsp.valid) begin
                    yt            = sat_st(p + ext(r_s3));
                    n_y3          = yt;
                    n_s3          = sat_st(ext(yt) + p);
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(yt) - ext(r_s4);
                    mul_req.c     = 32'(r_lpc);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_P4;
                end
            end
            ST_P4: begin
                if (mul_rsp.valid) begin
                    yt   = sat_st(p + ext(r_s4));
                    n_s4 = sat_st(ext(yt) + p);
                    n_t  = 25'(tfrac);
                    case (r_pos[15:14])
                        2'd0: begin
                            sum    = ext(yt);
                            n_mixb = r_y3;
                        end
                        2'd1: begin
                            sum    = ext(r_y3);
                            n_mixb = r_y2;
                        end
                        2'd2: begin
                            sum    = ext(r_y2);
                            n_mixb = r_y1;
                        end
                        default: begin
                            // top position: plain first-stage output
                            sum    = ext(r_y1);
                            n_mixb = r_y1;
                            n_t    = '0;
                        end
                    endcase
                    mul_req.start = 1'b1;
                    mul_req.a     = sum;
                    mul_req.c     = 32'(fpl_pkg::ONE25 - n_t);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_X1;
                end
            end
            ST_X1: begin
                if (mul_rsp.valid) begin
                    n_acc         = p;
                    mul_req.start = 1'b1;
                    mul_req.a     = ext(r_mixb);
                    mul_req.c     = 32'(r_t);
                    mul_req.sh    = 6'd24;
                    n_state       = ST_X2;
                end
            end
            ST_X2: begin
                if (mul_rsp.valid) begin
                    n_mc          = r_acc + p;
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(r_r24);
                    mul_req.c     = fpl_pkg::COMP_Q24;
                    mul_req.sh    = 6'd24;
                    n_state       = ST_C1;
                end
            end
            ST_C1: begin
                if (mul_rsp.valid) begin
                    sum           = fpl_pkg::ONE + p;
                    mul_req.start = 1'b1;
                    mul_req.a     = r_mc;
                    mul_req.c     = sum[31:0];
                    mul_req.sh    = 6'd24;
                    n_state       = ST_C2;
                end
            end
            ST_C2: begin
                // wait here until the output register is free
                if (mul_rsp.valid && (!r_ov || i_out_ready)) begin
                    sum     = ((p + RND) >>> LSH) <<< RSH;
                    oc      = (sum > O_MAX) ? O_MAX : ((sum < O_MIN) ? O_MIN : sum);
                    n_o     = oc[SAMPLE_WIDTH-1:0];
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_s4    <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_s4    <= n_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_mc   <= n_mc;
        r_lpc  <= n_lpc;
        r_ml   <= n_ml;
        r_g2   <= n_g2;
        r_t    <= n_t;
        r_r24  <= n_r24;
        r_neg  <= n_neg;
        r_y1   <= n_y1;
        r_y2   <= n_y2;
        r_y3   <= n_y3;
        r_mixb <= n_mixb;
        r_o    <= n_o;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_ov;
    assign o_sample_out = r_o;
    assign o_cfg_ready  = 1'b1;

endmodule
`default_nettype wire

// ===== hdl/fpl_mul.sv =====
// Shared signed-by-unsigned multiplier: 64 x 32 bit product in two 33 x 33 passes, then shift.
`default_nettype none
module fpl_mul (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fpl_pkg::t_mul_req i_req,
    output fpl_pkg::t_mul_rsp     o_rsp
);

    logic signed [63:0] r_a;
    logic [31:0]        r_c;
    logic [5:0]         r_sh;
    logic [1:0]         r_ph;
    logic               r_valid;
    logic [63:0]        r_plo;
    logic signed [64:0] r_phi;

    logic signed [96:0] full;
    logic signed [96:0] shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= 2'd0;
            r_valid <= 1'b0;
        end else if (i_req.start) begin
            r_a     <= i_req.a;
            r_c     <= i_req.c;
            r_sh    <= i_req.sh;
            r_ph    <= 2'd1;
            r_valid <= 1'b0;
        end else if (r_ph == 2'd1) begin
            r_plo <= 64'(r_a[31:0]) * 64'(r_c);
            r_ph  <= 2'd2;
        end else if (r_ph == 2'd2) begin
            r_phi   <= 65'($signed(r_a[63:32]) * $signed({1'b0, r_c}));
            r_ph    <= 2'd0;
            r_valid <= 1'b1;
        end
    end

    always_comb begin
        full    = $signed({r_phi, 32'd0}) + $signed({33'd0, r_plo});
        shifted = full >>> r_sh;
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.p     = shifted[63:0];

endmodule
`default_nettype wire

// ===== hdl/fpl_div.sv =====
// Shared unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module fpl_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fpl_pkg::t_div_req i_req,
    output fpl_pkg::t_div_rsp     o_rsp
);

    localparam int DW = fpl_pkg::DW;
    localparam int CW = fpl_pkg::DIV_CW;

    logic [DW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_valid;

    logic [DW:0] rs;
    logic        ge;

    always_comb begin
        rs = {r_rem[DW-1:0], r_q[DW-1]};
        ge = (rs >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_req.start) begin
            r_q     <= i_req.num;
            r_d     <= i_req.den;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else if (r_busy) begin
            r_rem <= ge ? (rs - {1'b0, r_d}) : rs;
            r_q   <= {r_q[DW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DW - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.q     = r_q;

endmodule
`default_nettype wire

// ===== hdl/fpl_cordic.sv =====
// Shared CORDIC, rotation (tan prewarp) or vectoring (atan limiter), one iteration per cycle.
`default_nettype none
module fpl_cordic (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fpl_pkg::t_cor_req i_req,
    output fpl_pkg::t_cor_rsp     o_rsp
);

    localparam int CW = fpl_pkg::CORDIC_CW;

    logic signed [63:0] r_x;
    logic signed [63:0] r_y;
    logic signed [63:0] r_z;
    logic               r_vec;
    logic [CW-1:0]      r_i;
    logic               r_busy;
    logic               r_valid;

    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] ang;
    logic               pos;

    always_comb begin
        dx  = r_y >>> r_i;
        dy  = r_x >>> r_i;
        ang = $signed(64'(fpl_pkg::atan_q30(r_i)));
        // vectoring drives y to zero, rotation drives z to zero
        pos = r_vec ? r_y[63] : ~r_z[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_req.start) begin
            r_x     <= i_req.x;
            r_y     <= i_req.y;
            r_z     <= i_req.z;
            r_vec   <= i_req.vec;
            r_i     <= '0;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else if (r_busy) begin
            if (pos) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ang;
            end
            r_i <= r_i + 1'b1;
            if (r_i == CW'(fpl_pkg::CORDIC_N - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.x     = r_x;
    assign o_rsp.y     = r_y;
    assign o_rsp.z     = r_z;

endmodule
`default_nettype wire

// ===== hdl/fpl_checker.sv =====
// Port-level checker for the ladder filter top, attached by bind.
`default_nettype none
module fpl_checker #(
    parameter int SAMPLE_WIDTH = fpl_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input wire logic [15:0]                    i_cutoff_hz,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [fpl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [15:0]                    i_cfg_data
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("output transaction dropped or changed while stalled");

    // an accepted sample occupies the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result delivered while sequencer busy");

    // no result can appear in the cycle after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared one cycle after acceptance");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid || !i_cfg_valid) |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind four_pole_ladder_lowpass_top fpl_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fpl_checker (.*);
`default_nettype wire

// ===== bench/tb_four_pole_ladder_lowpass_top.sv =====
// Self-checking bench for the four-pole ladder low-pass filter with a built-in predictor.
`default_nettype none
module tb_four_pole_ladder_lowpass_top;

    localparam int SW = 24;
    localparam longint FS = 96000;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic [15:0]          fc;
    } t_smp_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
    logic signed [SW-1:0] sample_in = '0;
    logic [15:0] cutoff_hz = '0, cfg_data = '0;
    logic [fpl_pkg::CFG_IDX_W-1:0] cfg_index = fpl_pkg::CFG_RESONANCE;
    logic in_ready, out_valid, cfg_ready;
    logic signed [SW-1:0] sample_out;

    four_pole_ladder_lowpass_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_sample_in(sample_in), .i_cutoff_hz(cutoff_hz),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_sample_out(sample_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] pr_res = 0, pr_pos = 0;
    longint s1 = 0, s2 = 0, s3 = 0, s4 = 0;
    longint cordic_tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    logic [15:0] res_set[6] = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd30000, 16'd8000};
    logic [15:0] pos_set[6] = '{16'd0, 16'd49152, 16'd65535, 16'd16384, 16'd8191, 16'd40000};

    t_smp_item pending[$];
    logic signed [SW-1:0] expected_out[$];
    int errors = 0, mismatches = 0;
    bit quiet_phase = 0;

    function automatic longint fl_mul(longint a, longint c, int sh);
        longint hi, lo;
        hi = a >>> sh;
        lo = a - (hi <<< sh);
        return hi * c + ((lo * c) >>> sh);
    endfunction

    function automatic longint clamp32(longint v);
        return v < -(64'sd1 <<< 31) ? -(64'sd1 <<< 31) :
               (v > (64'sd1 <<< 31) - 1 ? (64'sd1 <<< 31) - 1 : v);
    endfunction

    function automatic longint div_tz(longint num, longint den);
        longint q, r;
        q = num / den;
        r = num - q * den;
        return q * 64'sd16777216 + (r * 64'sd16777216) / den;
    endfunction

    function automatic longint sqrt_int(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint tan_of(longint z);
        longint x, y, dx, dy, g;
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= cordic_tab[i]; end
            else begin x += dx; y -= dy; z += cordic_tab[i]; end
        end
        if (y < 0) y = 0;
        if (x < 1) x = 1;
        g = longint'(($unsigned(y) << 24) / $unsigned(x));
        return g > (64'sd64 <<< 24) ? (64'sd64 <<< 24) : g;
    endfunction

    function automatic longint atan_of(longint u);
        longint x, y, z, dx, dy;
        x = 64'sd16777216;
        y = u;
        z = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin x += dx; y -= dy; z += cordic_tab[i]; end
            else begin x -= dx; y += dy; z -= cordic_tab[i]; end
        end
        return z >>> 6;
    endfunction

    function automatic longint pole(inout longint s, input longint in_v, input longint c);
        longint v, y;
        v = fl_mul(in_v - s, c, 24);
        y = clamp32(v + s);
        s = clamp32(y + v);
        return y;
    endfunction

    function automatic longint crossfade(longint a, longint b, longint t);
        return fl_mul(a, 64'sd16777216 - t, 24) + fl_mul(b, t, 24);
    endfunction

    function automatic logic signed [SW-1:0] ladder_step(t_smp_item it);
        longint unsigned theta, root;
        longint x, g, lpc, ml, r24, fbs, gg, y0, y1, y2, y3, y4, mc, comp, o, kq, ki, t;
        x = longint'(it.smp) * 2;
        theta = (64'(it.fc) * 64'd3373259426) / FS;
        if (theta > 64'd1652897119) theta = 64'd1652897119;
        g = tan_of(longint'(theta));
        lpc = (g * 64'sd16777216) / (g + 64'sd16777216);
        ml = 64'sd16777216 - lpc;
        r24 = longint'(pr_res > fpl_pkg::RES_MAX ? fpl_pkg::RES_MAX : pr_res) * 1792;
        fbs = fl_mul(s1, lpc, 24) + s2;
        fbs = fl_mul(fbs, lpc, 24) + s3;
        fbs = fl_mul(fbs, lpc, 24) + s4;
        fbs = fl_mul(fbs, ml, 24);
        gg = fl_mul(lpc, lpc, 24);
        gg = fl_mul(gg, gg, 24);
        y0 = clamp32(div_tz(x - fl_mul(fbs, r24, 24), 64'sd16777216 + fl_mul(gg, r24, 24)));
        y1 = pole(s1, y0, lpc);
        root = sqrt_int((64'd44000 * FS) << 30);
        if (root < 1) root = 1;
        kq = longint'((64'd970 << 47) / root);
        ki = longint'((root * 512) / 970);
        s1 = clamp32(fl_mul(atan_of(fl_mul(s1, kq, 32)), ki, 24));
        y2 = pole(s2, y1, lpc);
        y3 = pole(s3, y2, lpc);
        y4 = pole(s4, y3, lpc);
        t = longint'(pr_pos[13:0]) * 1024;
        case (pr_pos[15:14])
            2'd0: mc = crossfade(y4, y3, t);
            2'd1: mc = crossfade(y3, y2, t);
            2'd2: mc = crossfade(y2, y1, t);
            default: mc = y1;
        endcase
        comp = 64'sd16777216 + fl_mul(r24, longint'(fpl_pkg::COMP_Q24), 24);
        o = fl_mul(mc, comp, 24);
        o = (o + 1) >>> 1;
        if (o < -(64'sd1 <<< 23)) o = -(64'sd1 <<< 23);
        if (o > (64'sd1 <<< 23) - 1) o = (64'sd1 <<< 23) - 1;
        return o[SW-1:0];
    endfunction

    // input transaction taken at the last rising edge
    logic in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_valid && in_ready;
    end

    // sample driver
    int in_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                expected_out.push_back(ladder_step(pending.pop_front()));
                if (!quiet_phase && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 17);
            end
            if (!in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    in_valid <= 1'b1;
                    sample_in <= pending[0].smp;
                    cutoff_hz <= pending[0].fc;
                end else in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_out.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected output %0d", sample_out);
            end else if (expected_out[0] !== sample_out) begin
                errors++;
                if (mismatches++ < 10)
                    $display("mismatch: expected %0d actual %0d", expected_out[0], sample_out);
                void'(expected_out.pop_front());
            end else void'(expected_out.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            out_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end else out_ready <= 1'b1;
    end

    task automatic write_reg(logic [fpl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == fpl_pkg::CFG_RESONANCE) pr_res = val;
        else pr_pos = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() > 0 || in_valid || expected_out.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_smp_item rand_item();
        t_smp_item it;
        it.smp = SW'($urandom());
        case ($urandom_range(0, 3))
            0: it.fc = 16'($urandom_range(20, 2000));
            1: it.fc = 16'($urandom_range(0, 47000));
            2: it.fc = 16'($urandom_range(2000, 20000));
            default: it.fc = 16'($urandom());
        endcase
        return it;
    endfunction

    initial begin
        t_smp_item it;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes of sample and cutoff, including cutoff past Nyquist clamp
        write_reg(fpl_pkg::CFG_RESONANCE, 16'd32768);
        write_reg(fpl_pkg::CFG_MULTIMODE, 16'd0);
        for (int k = 0; k < 20; k++) begin
            it.smp = (k % 4 == 0) ? 24'sh7fffff : (k % 4 == 1) ? 24'sh800000 :
                     (k % 4 == 2) ? 24'sh000000 : 24'shffffff;
            it.fc = (k < 5) ? 16'd0 : (k < 10) ? 16'd47000 : (k < 15) ? 16'hffff : 16'd1000;
            pending.push_back(it);
        end
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(fpl_pkg::CFG_RESONANCE, res_set[ph]);
            write_reg(fpl_pkg::CFG_MULTIMODE, pos_set[ph]);
            if (ph == 5) quiet_phase = 1;
            for (int k = 0; k < 172; k++) pending.push_back(rand_item());
            drain();
        end
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
